// ===== sv/bobc_pkg.sv =====
// ----------------------------------------------------------------------------
// Bit offset block copy package
// Shared constants, request codes and controller/datapath link types.
// ----------------------------------------------------------------------------
package bobc_pkg;

  localparam int unsigned STORE_BYTES = 256;
  localparam int unsigned AddrW       = $clog2(STORE_BYTES);
  localparam int unsigned TypeW       = 2;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned BitPosW     = 11;
  localparam int unsigned CountW      = 12;
  localparam int unsigned SumW        = 13;

  localparam logic [SumW-1:0] StoreBits = SumW'(STORE_BYTES * 8);

  localparam logic [TypeW-1:0] REQ_LOAD_SRC = 2'd0;
  localparam logic [TypeW-1:0] REQ_LOAD_DST = 2'd1;
  localparam logic [TypeW-1:0] REQ_READ_DST = 2'd2;
  localparam logic [TypeW-1:0] REQ_COPY     = 2'd3;

  typedef struct packed {
    logic [TypeW-1:0]   req_type;
    logic [AddrW-1:0]   byte_addr;
    logic [ByteW-1:0]   byte_value;
    logic [BitPosW-1:0] src_bit;
    logic [BitPosW-1:0] dst_bit;
    logic [CountW-1:0]  bit_count;
  } req_t;

  typedef struct packed {
    logic capture;
    logic rd_dst;
    logic rd_first;
    logic rd_second;
    logic merge;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic stop;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/bobc_if.sv =====
// ----------------------------------------------------------------------------
// Bit offset block copy channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bobc_req_if;
  logic                        valid;
  logic                        ready;
  logic [bobc_pkg::TypeW-1:0]   req_type;
  logic [bobc_pkg::AddrW-1:0]   byte_addr;
  logic [bobc_pkg::ByteW-1:0]   byte_value;
  logic [bobc_pkg::BitPosW-1:0] src_bit;
  logic [bobc_pkg::BitPosW-1:0] dst_bit;
  logic [bobc_pkg::CountW-1:0]  bit_count;

  modport source (
    output valid, req_type, byte_addr, byte_value, src_bit, dst_bit, bit_count,
    input  ready
  );
  modport sink (
    input  valid, req_type, byte_addr, byte_value, src_bit, dst_bit, bit_count,
    output ready
  );
endinterface

interface bobc_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [bobc_pkg::ByteW-1:0] read_value;
  logic                      status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

// ===== sv/bit_offset_block_copy_top.sv =====
// ----------------------------------------------------------------------------
// Bit offset block copy
// Byte loads, destination reads and MSB-first bit-run copies between two stores.
// ----------------------------------------------------------------------------
// Loads go straight to the response; reads add one destination read; copies add one step of
// two reads and a merge per destination byte touched. One request at a time; ready is high
// only while the controller is idle, so a new request waits for the last response load.
// Each copy step uses two source reads and one destination read and write.
// Reset clears the controller and response valid; both stores are undefined
// until loaded.
module bit_offset_block_copy_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  bobc_req_if.sink   req_i,
  bobc_rsp_if.source rsp_o
);
  import bobc_pkg::*;

  req_t  req_pl;
  cmd_t  cmd;
  stat_t stat;

  assign req_pl = '{
    req_type:   req_i.req_type,
    byte_addr:  req_i.byte_addr,
    byte_value: req_i.byte_value,
    src_bit:    req_i.src_bit,
    dst_bit:    req_i.dst_bit,
    bit_count:  req_i.bit_count
  };

  bobc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bobc_datapath u_datapath (
    .clk_i,
    .rst_ni,
    .req_i        (req_pl),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .read_value_o (rsp_o.read_value),
    .status_o     (rsp_o.status)
  );

endmodule

// ===== sv/bobc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bobc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bobc_datapath.sv =====
// ----------------------------------------------------------------------------
// Bit offset block copy datapath
// Source and destination stores, copy cursors, byte merge and response register.
// ----------------------------------------------------------------------------
module bobc_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bobc_pkg::req_t            req_i,
  input  bobc_pkg::cmd_t            cmd_i,
  output bobc_pkg::stat_t           stat_o,
  output logic                      rsp_valid_o,
  input  logic                      rsp_ready_i,
  output logic [bobc_pkg::ByteW-1:0] read_value_o,
  output logic                      status_o
);
  import bobc_pkg::*;

  logic [TypeW-1:0]  type_q;
  logic [AddrW-1:0]  addr_q;
  logic [CountW-1:0] spos_q, spos_d;
  logic [CountW-1:0] dpos_q, dpos_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic              err_q;
  logic [ByteW-1:0]  a_q;
  logic [ByteW-1:0]  d_q;
  logic              rsp_valid_q;
  logic [ByteW-1:0]  read_value_q;
  logic              status_q;

  logic [SumW-1:0]   src_end, dst_end;
  logic [2:0]        soff, doff;
  logic [3:0]        space, n, end_off;
  logic [AddrW-1:0]  sbyte, dbyte;
  logic [15:0]       window;
  logic [ByteW-1:0]  shifted, mask, merged;

  logic              src_we, dst_we, src_re, dst_re;
  logic [AddrW-1:0]  dst_waddr, src_raddr, dst_raddr;
  logic [ByteW-1:0]  dst_wdata, src_rdata, dst_rdata;

  assign src_end = SumW'(req_i.src_bit) + SumW'(req_i.bit_count);
  assign dst_end = SumW'(req_i.dst_bit) + SumW'(req_i.bit_count);

  assign soff    = spos_q[2:0];
  assign doff    = dpos_q[2:0];
  assign sbyte   = spos_q[AddrW+2:3];
  assign dbyte   = dpos_q[AddrW+2:3];
  assign space   = 4'd8 - {1'b0, doff};
  assign n       = (rem_q < CountW'(space)) ? rem_q[3:0] : space;
  assign end_off = {1'b0, doff} + n;
  assign window  = {a_q, src_rdata} << soff;
  assign shifted = window[15:8] >> doff;
  assign mask    = (8'hFF >> doff) & ~(8'hFF >> end_off);
  assign merged  = (d_q & ~mask) | (shifted & mask);

  assign src_we    = cmd_i.capture && (req_i.req_type == REQ_LOAD_SRC);
  assign dst_we    = (cmd_i.capture && (req_i.req_type == REQ_LOAD_DST)) || cmd_i.merge;
  assign dst_waddr = cmd_i.merge ? dbyte : req_i.byte_addr;
  assign dst_wdata = cmd_i.merge ? merged : req_i.byte_value;
  assign src_re    = cmd_i.rd_first || cmd_i.rd_second;
  assign src_raddr = cmd_i.rd_second ? sbyte + AddrW'(1) : sbyte;
  assign dst_re    = cmd_i.rd_first || cmd_i.rd_dst;
  assign dst_raddr = cmd_i.rd_dst ? addr_q : dbyte;

  bobc_ram #(.WIDTH(ByteW), .DEPTH(STORE_BYTES)) u_src_ram (
    .clk_i,
    .we_i    (src_we),
    .waddr_i (req_i.byte_addr),
    .wdata_i (req_i.byte_value),
    .re_i    (src_re),
    .raddr_i (src_raddr),
    .rdata_o (src_rdata)
  );

  bobc_ram #(.WIDTH(ByteW), .DEPTH(STORE_BYTES)) u_dst_ram (
    .clk_i,
    .we_i    (dst_we),
    .waddr_i (dst_waddr),
    .wdata_i (dst_wdata),
    .re_i    (dst_re),
    .raddr_i (dst_raddr),
    .rdata_o (dst_rdata)
  );

  always_comb begin
    spos_d = spos_q;
    dpos_d = dpos_q;
    rem_d  = rem_q;
    if (cmd_i.capture) begin
      spos_d = CountW'(req_i.src_bit);
      dpos_d = CountW'(req_i.dst_bit);
      rem_d  = req_i.bit_count;
    end else if (cmd_i.merge) begin
      spos_d = spos_q + CountW'(n);
      dpos_d = dpos_q + CountW'(n);
      rem_d  = rem_q - CountW'(n);
    end
  end

  always_ff @(posedge clk_i) begin
    spos_q <= spos_d;
    dpos_q <= dpos_d;
    rem_q  <= rem_d;
    if (cmd_i.capture) begin
      type_q <= req_i.req_type;
      addr_q <= req_i.byte_addr;
      err_q  <= (src_end > StoreBits) || (dst_end > StoreBits);
    end
    if (cmd_i.rd_second) begin
      a_q <= src_rdata;
      d_q <= dst_rdata;
    end
    if (cmd_i.load_out) begin
      read_value_q <= (type_q == REQ_READ_DST) ? dst_rdata : '0;
      status_q     <= (type_q == REQ_COPY) && err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  assign stat_o.stop     = err_q || (rem_q == '0);
  assign stat_o.out_free = !rsp_valid_q || rsp_ready_i;
  assign rsp_valid_o     = rsp_valid_q;
  assign read_value_o    = read_value_q;
  assign status_o        = status_q;

endmodule

// ===== sv/bobc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bit offset block copy controller
// Sequences request capture, per-byte copy steps and response hand-off.
// ----------------------------------------------------------------------------
module bobc_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  input  logic [bobc_pkg::TypeW-1:0] req_type_i,
  output logic                      req_ready_o,
  input  bobc_pkg::stat_t           stat_i,
  output bobc_pkg::cmd_t            cmd_o
);
  import bobc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD0  = 3'd1;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_MRG  = 3'd3;
  localparam logic [2:0] S_RDW  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          case (req_type_i) inside
            REQ_LOAD_SRC, REQ_LOAD_DST: state_d = S_OUT;
            REQ_READ_DST:               state_d = S_RDW;
            default:                    state_d = S_RD0;
          endcase
        end
      end
      S_RD0: begin
        if (stat_i.stop) begin
          state_d = S_OUT;
        end else begin
          cmd_o.rd_first = 1'b1;
          state_d        = S_RD1;
        end
      end
      S_RD1: begin
        cmd_o.rd_second = 1'b1;
        state_d         = S_MRG;
      end
      S_MRG: begin
        cmd_o.merge = 1'b1;
        state_d     = S_RD0;
      end
      S_RDW: begin
        cmd_o.rd_dst = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
